// File: src/i32div_pkg.sv
// Package for the 32-bit integer divider.
// Holds the data width, the opcode codes and the stage record passed along the cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i32div_pkg;

    localparam int DATA_WIDTH = 32;

    typedef enum logic {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } op_t;

    // Working record of one item inside the chain. num shifts dividend bits
    // out at the top and quotient bits in at the bottom.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] num;
        logic [DATA_WIDTH-1:0] den;
        logic                  neg_q;
        logic                  neg_r;
        logic                  dz;
    } stage_t;

endpackage

`default_nettype wire

// File: src/i32div_if.sv
// Valid/ready channel interfaces for the divider request and response items.
// Depends on i32div_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface i32div_req_if
    import i32div_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
    logic                  opcode;

    modport source (output valid, output dividend, output divisor, output opcode,
                    input ready);
    modport sink   (input valid, input dividend, input divisor, input opcode,
                    output ready);
endinterface

interface i32div_rsp_if
    import i32div_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
    logic                  divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: src/i32div_prep.sv
// Entry stage: takes operand magnitudes for signed division and records sign fixes.
// Depends on i32div_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i32div_prep
    import i32div_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    input  wire logic                  opcode,
    output logic                       valid_out,
    output stage_t                     stage_out
);

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;
    logic   is_signed;
    logic   n_neg;
    logic   d_neg;

    always_comb
    begin
        is_signed           = (opcode == OP_SIGNED);
        n_neg               = is_signed & dividend[DATA_WIDTH-1];
        d_neg               = is_signed & divisor[DATA_WIDTH-1];
        stage_next.rem      = '0;
        stage_next.num      = n_neg ? (~dividend) + DATA_WIDTH'(1) : dividend;
        stage_next.den      = d_neg ? (~divisor) + DATA_WIDTH'(1) : divisor;
        stage_next.neg_q    = n_neg ^ d_neg;
        stage_next.neg_r    = n_neg;
        stage_next.dz       = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

// File: src/i32div_cell.sv
// One restoring-division cell: produces one quotient bit per item and registers the result.
// Depends on i32div_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i32div_cell
    import i32div_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   valid_in,
    input  wire stage_t stage_in,
    output logic        valid_out,
    output stage_t      stage_out
);

    logic                  valid_reg;
    stage_t                stage_reg;
    stage_t                stage_next;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH+1:0] diff;
    logic                  take;

    always_comb
    begin
        // Shift in the next dividend bit, then trial-subtract the divisor.
        rem_sh         = {stage_in.rem, stage_in.num[DATA_WIDTH-1]};
        diff           = {1'b0, rem_sh} - {2'b00, stage_in.den};
        take           = ~diff[DATA_WIDTH+1];
        stage_next     = stage_in;
        stage_next.rem = take ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        stage_next.num = {stage_in.num[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

// File: src/i32div_out.sv
// Exit stage: applies sign fixes and the zero-divisor override, then an output
// register with a skid entry. Depends on i32div_pkg and the response interface.
`timescale 1ns / 1ps
`default_nettype none

module i32div_out
    import i32div_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    valid_in,
    input  wire stage_t  stage_in,
    output logic         advance,
    i32div_rsp_if.source rsp
);

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_quo_reg;
    logic [DATA_WIDTH-1:0] out_rem_reg;
    logic                  out_dz_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] skid_quo_reg;
    logic [DATA_WIDTH-1:0] skid_rem_reg;
    logic                  skid_dz_reg;
    logic [DATA_WIDTH-1:0] quo_fix;
    logic [DATA_WIDTH-1:0] rem_fix;
    logic                  push;
    logic                  load_out;

    always_comb
    begin
        if (stage_in.dz)
        begin
            quo_fix = '0;
            rem_fix = '0;
        end
        else
        begin
            quo_fix = stage_in.neg_q ? (~stage_in.num) + DATA_WIDTH'(1) : stage_in.num;
            rem_fix = stage_in.neg_r ? (~stage_in.rem) + DATA_WIDTH'(1) : stage_in.rem;
        end
    end

    // The chain holds whenever the skid entry is occupied.
    assign advance  = ~skid_valid_reg;
    assign push     = valid_in & advance;
    assign load_out = ~out_valid_reg | rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_quo_reg <= skid_quo_reg;
                out_rem_reg <= skid_rem_reg;
                out_dz_reg  <= skid_dz_reg;
            end
            else
            begin
                out_quo_reg <= quo_fix;
                out_rem_reg <= rem_fix;
                out_dz_reg  <= stage_in.dz;
            end
        end
        else if (push)
        begin
            skid_quo_reg <= quo_fix;
            skid_rem_reg <= rem_fix;
            skid_dz_reg  <= stage_in.dz;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.quotient       = out_quo_reg;
    assign rsp.remainder      = out_rem_reg;
    assign rsp.divide_by_zero = out_dz_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while output register empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready && push) |=> skid_valid_reg)
        else $error("item from chain lost during output stall");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dz_reg) |-> (out_quo_reg == '0 && out_rem_reg == '0))
        else $error("zero divisor result carries nonzero data");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rsp.ready) |=> !skid_valid_reg)
        else $error("skid entry not drained on ready");

endmodule

`default_nettype wire

// File: src/int32_divide_quotient_remainder_top.sv
// Top level of the pipelined integer divider (unsigned and signed, quotient and remainder).
// Depends on i32div_pkg, i32div_if, i32div_prep, i32div_cell and i32div_out.
//
// Usage:
//   req carries dividend, divisor and opcode (0 unsigned, 1 signed); rsp returns
//   quotient, remainder and divide_by_zero. Both are valid/ready channels; an item
//   moves at a rising edge with valid and ready high.
//   Pipeline: one entry stage (operand magnitudes), a row of 32 restoring cells,
//   one quotient bit each, and an output register with one skid entry.
//   rsp.valid rises once the item has passed the entry register, the cell
//   registers and the output register; it can then be taken when rsp is ready.
//   Throughput: one item per cycle unless the output stalls; each cell holds at most one item.
//   Signed results truncate toward zero, remainder takes the dividend's sign,
//   the most negative value over minus one wraps to itself. A zero divisor
//   gives divide_by_zero = 1 with zero quotient and remainder.
//   Stall: when rsp is not ready, the next item lands in the skid entry and the
//   whole chain then holds, dropping req.ready until the skid entry drains.
//   Reset (rst_n low, asynchronous) empties every stage; items in flight are lost.
`timescale 1ns / 1ps
`default_nettype none

module int32_divide_quotient_remainder_top
    import i32div_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    i32div_req_if.sink   req,
    i32div_rsp_if.source rsp
);

    logic   advance;
    logic   chain_valid [0:DATA_WIDTH];
    stage_t chain_stage [0:DATA_WIDTH];

    assign req.ready = advance;

    i32div_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (req.valid),
        .dividend  (req.dividend),
        .divisor   (req.divisor),
        .opcode    (req.opcode),
        .valid_out (chain_valid[0]),
        .stage_out (chain_stage[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        i32div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (chain_valid[i]),
            .stage_in  (chain_stage[i]),
            .valid_out (chain_valid[i+1]),
            .stage_out (chain_stage[i+1])
        );
    end

    i32div_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (chain_valid[DATA_WIDTH]),
        .stage_in (chain_stage[DATA_WIDTH]),
        .advance  (advance),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// File: dv/int32_divide_quotient_remainder_top_tb.sv
// Self-checking testbench for the pipelined 32-bit divider (quotient, remainder, zero flag).
// Depends on i32div_pkg, i32div_if and the int32_divide_quotient_remainder_top RTL.
// A directed table runs first, then random items with idling, a long output hold and a drain pause.
`timescale 1ns / 1ps

module int32_divide_quotient_remainder_top_tb;
    import i32div_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_MAX = 5000;
    localparam int IDLE_PERCENT = 30;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t quotient;
        word_t remainder;
        logic  dz;
    } div_result_t;

    typedef struct packed {
        word_t       dividend;
        word_t       divisor;
        op_t         op;
        logic        typed;
        div_result_t want;
    } div_case_t;

    localparam int NUM_CASES = 24;

    // Rows with typed = 1 carry their answer; the rest go through the predictor.
    div_case_t directed_cases [0:NUM_CASES-1] = '{
        '{32'h00000000, 32'h00000001, OP_UNSIGNED, 1'b1, '{32'h00000000, 32'h00000000, 1'b0}},
        '{32'hFFFFFFFF, 32'h00000001, OP_UNSIGNED, 1'b1, '{32'hFFFFFFFF, 32'h00000000, 1'b0}},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, OP_UNSIGNED, 1'b1, '{32'h00000001, 32'h00000000, 1'b0}},
        '{32'h00000001, 32'hFFFFFFFF, OP_UNSIGNED, 1'b1, '{32'h00000000, 32'h00000001, 1'b0}},
        '{32'h12345678, 32'h00000000, OP_UNSIGNED, 1'b1, '{32'h00000000, 32'h00000000, 1'b1}},
        '{32'h80000000, 32'h00000000, OP_SIGNED,   1'b1, '{32'h00000000, 32'h00000000, 1'b1}},
        '{32'h80000000, 32'hFFFFFFFF, OP_SIGNED,   1'b1, '{32'h80000000, 32'h00000000, 1'b0}},
        '{32'h80000000, 32'hFFFFFFFF, OP_UNSIGNED, 1'b1, '{32'h00000000, 32'h80000000, 1'b0}},
        '{32'h00000007, 32'h00000002, OP_SIGNED,   1'b1, '{32'h00000003, 32'h00000001, 1'b0}},
        '{32'hFFFFFFF9, 32'h00000002, OP_SIGNED,   1'b1, '{32'hFFFFFFFD, 32'hFFFFFFFF, 1'b0}},
        '{32'h00000007, 32'hFFFFFFFE, OP_SIGNED,   1'b1, '{32'hFFFFFFFD, 32'h00000001, 1'b0}},
        '{32'hFFFFFFF9, 32'hFFFFFFFE, OP_SIGNED,   1'b1, '{32'h00000003, 32'hFFFFFFFF, 1'b0}},
        '{32'h7FFFFFFF, 32'h80000000, OP_SIGNED,   1'b1, '{32'h00000000, 32'h7FFFFFFF, 1'b0}},
        '{32'h80000000, 32'h80000000, OP_SIGNED,   1'b1, '{32'h00000001, 32'h00000000, 1'b0}},
        '{32'h80000000, 32'h00000001, OP_SIGNED,   1'b1, '{32'h80000000, 32'h00000000, 1'b0}},
        '{32'h7FFFFFFF, 32'hFFFFFFFF, OP_SIGNED,   1'b1, '{32'h80000001, 32'h00000000, 1'b0}},
        '{32'h00000005, 32'h00000005, OP_UNSIGNED, 1'b1, '{32'h00000001, 32'h00000000, 1'b0}},
        '{32'h00000000, 32'h00000000, OP_UNSIGNED, 1'b1, '{32'h00000000, 32'h00000000, 1'b1}},
        '{32'hDEADBEEF, 32'h00001234, OP_UNSIGNED, 1'b0, '0},
        '{32'hDEADBEEF, 32'h00001234, OP_SIGNED,   1'b0, '0},
        '{32'h80000000, 32'h00000003, OP_SIGNED,   1'b0, '0},
        '{32'hFFFFFFFF, 32'h0000FFFF, OP_UNSIGNED, 1'b0, '0},
        '{32'hAAAAAAAA, 32'h55555555, OP_UNSIGNED, 1'b0, '0},
        '{32'h55555555, 32'hAAAAAAAA, OP_SIGNED,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    i32div_req_if req_ch ();
    i32div_rsp_if rsp_ch ();

    int32_divide_quotient_remainder_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Travels with the offered item so the monitor sees it in step with req.
    logic        offered_typed;
    div_result_t offered_want;

    div_result_t awaited_results [$];

    bit idle_enable;
    bit hold_request;
    int hold_left;
    int error_count;
    int items_sent;
    int results_seen;
    int signed_count;
    int zero_div_count;
    int input_stall_cycles;
    int quiet_cycles;

    // Restoring division on magnitudes, then sign fix-up for the signed form.
    function automatic div_result_t predict_division(word_t a, word_t b, op_t op);
        div_result_t res;
        word_t       n_mag;
        word_t       d_mag;
        word_t       quo;
        word_t       rem;
        logic        n_neg;
        logic        d_neg;
        logic        carry;
        int          i;
        res = '0;
        if (b == '0)
        begin
            res.dz = 1'b1;
            return res;
        end
        n_neg = (op == OP_SIGNED) && a[DATA_WIDTH-1];
        d_neg = (op == OP_SIGNED) && b[DATA_WIDTH-1];
        n_mag = n_neg ? -a : a;
        d_mag = d_neg ? -b : b;
        quo = '0;
        rem = '0;
        for (i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            carry = rem[DATA_WIDTH-1];
            rem = {rem[DATA_WIDTH-2:0], n_mag[i]};
            if (carry || rem >= d_mag)
            begin
                rem = rem - d_mag;
                quo[i] = 1'b1;
            end
        end
        res.quotient  = (n_neg != d_neg) ? -quo : quo;
        res.remainder = n_neg ? -rem : rem;
        return res;
    endfunction

    function automatic word_t pick_operand();
        word_t v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = v >> $urandom_range(1, DATA_WIDTH - 1);
            1: v = -word_t'($urandom_range(0, 16));
            2: v = word_t'($urandom_range(0, 16));
            3: v = {1'b1, {(DATA_WIDTH - 1){1'b0}}} + word_t'($urandom_range(0, 3));
            4: v = {1'b0, {(DATA_WIDTH - 1){1'b1}}} - word_t'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    task automatic offer_division(word_t a, word_t b, op_t op, logic typed, div_result_t want);
        while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.dividend <= a;
        req_ch.divisor  <= b;
        req_ch.opcode   <= op;
        offered_typed   <= typed;
        offered_want    <= want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic offer_random_division();
        word_t a;
        word_t b;
        int    pick;
        a = pick_operand();
        pick = $urandom_range(0, 99);
        if (pick < 4)
            b = '0;
        else if (pick < 8)
            b = '1;
        else
            b = pick_operand();
        offer_division(a, b, op_t'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic wait_for_results();
        while (results_seen < items_sent)
            @(posedge clk);
    endtask

    // Output side: random back-pressure, plus one long hold on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Monitor: predict on request accept, compare on response accept.
    always @(posedge clk)
    begin
        div_result_t exp_res;
        if (rst_n)
        begin
            if (req_ch.valid && !req_ch.ready)
                input_stall_cycles++;
            if (req_ch.valid && req_ch.ready)
            begin
                exp_res = offered_typed ? offered_want :
                    predict_division(req_ch.dividend, req_ch.divisor, op_t'(req_ch.opcode));
                awaited_results.push_back(exp_res);
                if (req_ch.opcode == OP_SIGNED)
                    signed_count++;
                if (req_ch.divisor == '0)
                    zero_div_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result q=%h r=%h dz=%b", $time,
                             rsp_ch.quotient, rsp_ch.remainder, rsp_ch.divide_by_zero);
                    error_count++;
                end
                else
                begin
                    exp_res = awaited_results.pop_front();
                    if (rsp_ch.quotient !== exp_res.quotient)
                    begin
                        $display("%0t: quotient expected %h actual %h", $time,
                                 exp_res.quotient, rsp_ch.quotient);
                        error_count++;
                    end
                    if (rsp_ch.remainder !== exp_res.remainder)
                    begin
                        $display("%0t: remainder expected %h actual %h", $time,
                                 exp_res.remainder, rsp_ch.remainder);
                        error_count++;
                    end
                    if (rsp_ch.divide_by_zero !== exp_res.dz)
                    begin
                        $display("%0t: divide_by_zero expected %b actual %b", $time,
                                 exp_res.dz, rsp_ch.divide_by_zero);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles without any accepted item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                         quiet_cycles, awaited_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.dividend <= '0;
        req_ch.divisor  <= '0;
        req_ch.opcode   <= OP_UNSIGNED;
        offered_typed   <= 1'b0;
        offered_want    <= '0;
        idle_enable = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < NUM_CASES; k++)
            offer_division(directed_cases[k].dividend, directed_cases[k].divisor,
                           directed_cases[k].op, directed_cases[k].typed,
                           directed_cases[k].want);

        // Hold the input until the pipe has emptied.
        req_ch.valid <= 1'b0;
        wait_for_results();

        // Hold the output long enough to fill the chain and stall the input.
        for (k = 0; k < 250; k++)
        begin
            if (k == 60)
                hold_request = 1'b1;
            offer_random_division();
        end

        idle_enable = 1'b0;
        for (k = 0; k < 150; k++)
            offer_random_division();
        idle_enable = 1'b1;

        req_ch.valid <= 1'b0;
        wait_for_results();

        for (k = 0; k < 230; k++)
            offer_random_division();
        req_ch.valid <= 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            error_count++;
        end
        $display("Ran %0d divisions (%0d signed, %0d by zero), %0d results checked.",
                 items_sent, signed_count, zero_div_count, results_seen);
        $display("Input stalled %0d cycles, incl. a %0d-cycle output hold; %0d errors.",
                 input_stall_cycles, HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
